// ===== rtl/ntpm_pkg.sv =====
// Shared types and constants of the nearest timestamp pair matcher.
package ntpm_pkg;

  localparam int unsigned STAMP_W  = 27;
  localparam int unsigned TOL_W    = 16;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned ACTION_W = 2;

  localparam logic [STAMP_W-1:0] STAMP_MAX = STAMP_W'(86399999);
  localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(500);

  localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_START  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [STAMP_W-1:0]  stamp_ms;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] a_index;
    logic [IDX_W-1:0] b_index;
    logic [TOL_W-1:0] gap_ms;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic      pair;
    logic      fin;
    out_word_t res;
  } walk_evt_t;

endpackage

// ===== rtl/nearest_timestamp_pair_matcher.sv =====
// Top level of the nearest timestamp pair matcher.
//
// Input words carry an action and a timestamp. A load action appends the
// clamped timestamp to list A or list B; loads into a full list
// are dropped. A start action runs a merge join of both lists and returns one
// output word per matched pair, the final one flagged last, or a single end
// marker with found low when nothing matched. Both lists are empty afterwards.
// The input stalls for the whole run: the walk makes its comparisons one at a
// time and then passes through an end state. Each cycle does one read of each
// list RAM.
// A matched pair waits in a pending register until the next pair or the end
// state, so the first word appears in the cycle after the second match or the
// end state is taken; the last word appears in the cycle after the end state.
// When the receiver stalls, the walk pauses only when a word must be pushed
// into the full output register.
// Reset empties both lists, sets the tolerance to 500 ms and drops any word in
// flight; the list RAMs are not cleared.
module nearest_timestamp_pair_matcher #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ntpm_pkg::TOL_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ntpm_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ntpm_pkg::out_word_t          out_word_o
);
  import ntpm_pkg::*;

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  logic [CW-1:0]      a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [TOL_W-1:0]   tol_q;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;
  logic               pend_valid_q, pend_valid_d;
  out_word_t          pend_q, pend_d;

  logic               accept, start, we_a, we_b, busy, hold, out_busy;
  logic [STAMP_W-1:0] stamp_c, a_rdata, b_rdata;
  logic [AW-1:0]      a_raddr, b_raddr;
  walk_evt_t          evt;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = accept && (in_word_i.action == ACT_START);
  assign stamp_c    = (in_word_i.stamp_ms > STAMP_MAX) ? STAMP_MAX : in_word_i.stamp_ms;
  assign we_a       = accept && (in_word_i.action == ACT_LOAD_A) && (a_cnt_q < CW'(LIST_DEPTH));
  assign we_b       = accept && (in_word_i.action == ACT_LOAD_B) && (b_cnt_q < CW'(LIST_DEPTH));

  assign out_busy = out_valid_q && out_stall_i;
  assign hold     = out_busy && ((evt.pair && pend_valid_q) || evt.fin);

  ntpm_ram #(
    .WIDTH(STAMP_W),
    .DEPTH(LIST_DEPTH)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(a_cnt_q[AW-1:0]),
    .wdata_i(stamp_c),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  ntpm_ram #(
    .WIDTH(STAMP_W),
    .DEPTH(LIST_DEPTH)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(b_cnt_q[AW-1:0]),
    .wdata_i(stamp_c),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  ntpm_walk #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .a_cnt_i  (a_cnt_q),
    .b_cnt_i  (b_cnt_q),
    .tol_i    (tol_q),
    .a_rdata_i(a_rdata),
    .b_rdata_i(b_rdata),
    .hold_i   (hold),
    .a_raddr_o(a_raddr),
    .b_raddr_o(b_raddr),
    .evt_o    (evt),
    .busy_o   (busy)
  );

  always_comb begin
    a_cnt_d      = a_cnt_q;
    b_cnt_d      = b_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;

    if (we_a) begin
      a_cnt_d = a_cnt_q + CW'(1);
    end
    if (we_b) begin
      b_cnt_d = b_cnt_q + CW'(1);
    end

    if (evt.pair && !hold) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_q;
      end
      pend_valid_d = 1'b1;
      pend_d       = evt.res;
    end

    if (evt.fin && !hold) begin
      out_valid_d = 1'b1;
      if (pend_valid_q) begin
        out_d      = pend_q;
        out_d.last = 1'b1;
      end else begin
        out_d      = '0;
        out_d.last = 1'b1;
      end
      pend_valid_d = 1'b0;
      a_cnt_d      = '0;
      b_cnt_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q      <= '0;
      b_cnt_q      <= '0;
      tol_q        <= TOL_RESET;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      a_cnt_q      <= a_cnt_d;
      b_cnt_q      <= b_cnt_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/ntpm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ntpm_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ntpm_walk.sv =====
// Merge-join walker that steps the driver index and the shared cursor through both list RAMs.
module ntpm_walk #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]   a_cnt_i,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]   b_cnt_i,
  input  logic [ntpm_pkg::TOL_W-1:0]        tol_i,
  input  logic [ntpm_pkg::STAMP_W-1:0]      a_rdata_i,
  input  logic [ntpm_pkg::STAMP_W-1:0]      b_rdata_i,
  input  logic                              hold_i,
  output logic [$clog2(LIST_DEPTH)-1:0]     a_raddr_o,
  output logic [$clog2(LIST_DEPTH)-1:0]     b_raddr_o,
  output ntpm_pkg::walk_evt_t               evt_o,
  output logic                              busy_o
);
  import ntpm_pkg::*;

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic               a_drv_q, a_drv_d;
  logic [CW-1:0]      drv_n_q, drv_n_d;
  logic [CW-1:0]      oth_n_q, oth_n_d;
  logic [AW-1:0]      i_q, i_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic               have_q, have_d;
  logic [STAMP_W-1:0] best_q, best_d;
  logic [AW-1:0]      bidx_q, bidx_d;

  logic [STAMP_W-1:0] drv_val, oth_val, gap, best_sel;
  logic [AW-1:0]      idx_sel;
  logic [CW-1:0]      start_drv_n;
  logic               take, more, fin_entry;

  always_comb begin
    drv_val     = a_drv_q ? a_rdata_i : b_rdata_i;
    oth_val     = a_drv_q ? b_rdata_i : a_rdata_i;
    gap         = (drv_val >= oth_val) ? (drv_val - oth_val) : (oth_val - drv_val);
    take        = !have_q || (gap <= best_q);
    more        = (CW'(cur_q) + CW'(1)) < oth_n_q;
    fin_entry   = !take || !more;
    best_sel    = take ? gap : best_q;
    idx_sel     = take ? cur_q : bidx_q;
    start_drv_n = (a_cnt_i <= b_cnt_i) ? a_cnt_i : b_cnt_i;

    state_d = state_q;
    a_drv_d = a_drv_q;
    drv_n_d = drv_n_q;
    oth_n_d = oth_n_q;
    i_d     = i_q;
    cur_d   = cur_q;
    have_d  = have_q;
    best_d  = best_q;
    bidx_d  = bidx_q;
    evt_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          a_drv_d = a_cnt_i <= b_cnt_i;
          drv_n_d = start_drv_n;
          oth_n_d = (a_cnt_i <= b_cnt_i) ? b_cnt_i : a_cnt_i;
          i_d     = '0;
          cur_d   = '0;
          have_d  = 1'b0;
          state_d = (start_drv_n == '0) ? ST_FIN : ST_WALK;
        end
      end
      ST_WALK: begin
        if (fin_entry && (best_sel <= STAMP_W'(tol_i))) begin
          evt_o.pair        = 1'b1;
          evt_o.res.found   = 1'b1;
          evt_o.res.a_index = a_drv_q ? IDX_W'(i_q) : IDX_W'(idx_sel);
          evt_o.res.b_index = a_drv_q ? IDX_W'(idx_sel) : IDX_W'(i_q);
          evt_o.res.gap_ms  = best_sel[TOL_W-1:0];
          evt_o.res.last    = 1'b0;
        end
        if (!hold_i) begin
          if (!fin_entry) begin
            have_d = 1'b1;
            best_d = gap;
            bidx_d = cur_q;
            cur_d  = cur_q + AW'(1);
          end else begin
            have_d = 1'b0;
            i_d    = i_q + AW'(1);
            cur_d  = take ? cur_q : (cur_q - AW'(1));
            if ((CW'(i_q) + CW'(1)) == drv_n_q) begin
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_FIN: begin
        evt_o.fin = 1'b1;
        if (!hold_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    a_raddr_o = a_drv_d ? i_d : cur_d;
    b_raddr_o = a_drv_d ? cur_d : i_d;
  end

  assign busy_o = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_drv_q <= a_drv_d;
    drv_n_q <= drv_n_d;
    oth_n_q <= oth_n_d;
    i_q     <= i_d;
    cur_q   <= cur_d;
    have_q  <= have_d;
    best_q  <= best_d;
    bidx_q  <= bidx_d;
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the nearest timestamp pair matcher.
`timescale 1ns / 1ps

module tb_top;
  import ntpm_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned LIMIT = 1000000;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic     drain;
    in_word_t word;
  } pend_item_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [TOL_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_word;

  pend_item_t        pend_q[$];
  out_word_t         match_q[$];

  logic [STAMP_W-1:0] list_a [DEPTH];
  logic [STAMP_W-1:0] list_b [DEPTH];
  int unsigned        cnt_a = 0;
  int unsigned        cnt_b = 0;
  logic [TOL_W-1:0]   tol_model = TOL_RESET;

  int unsigned n_queued = 0;
  int unsigned n_bad = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  bit          word_taken = 1'b0;
  bit          calm = 1'b0;
  bit          press_arm = 1'b0;
  bit          hold_done = 1'b0;
  pend_item_t  head;
  out_word_t   want;

  nearest_timestamp_pair_matcher #(
    .LIST_DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_len(bit calm_now);
    int unsigned r;
    if (calm_now) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(60, 68);
    if (r == 1) return 0;
    return $urandom_range(1, 10);
  endfunction

  task automatic merge_join();
    bit          a_drv;
    bit          have;
    bit          going;
    bit          held_ok;
    int unsigned drv_n;
    int unsigned oth_n;
    int unsigned cur;
    int unsigned i;
    int unsigned best;
    int unsigned best_idx;
    int unsigned d;
    int unsigned dv;
    int unsigned ov;
    out_word_t   held;
    a_drv = (cnt_a <= cnt_b);
    drv_n = a_drv ? cnt_a : cnt_b;
    oth_n = a_drv ? cnt_b : cnt_a;
    cur = 0;
    held_ok = 1'b0;
    held = '0;
    for (i = 0; i < drv_n; i++) begin
      dv = a_drv ? list_a[i] : list_b[i];
      have = 1'b0;
      best = 0;
      best_idx = 0;
      going = 1'b1;
      while (going && cur < oth_n) begin
        ov = a_drv ? list_b[cur] : list_a[cur];
        d = (dv >= ov) ? dv - ov : ov - dv;
        if (!have || d <= best) begin
          have = 1'b1;
          best = d;
          best_idx = cur;
          cur++;
        end else begin
          going = 1'b0;
        end
      end
      if (cur > 0) cur--;
      if (have && best <= tol_model) begin
        if (held_ok) match_q = {match_q, held};
        held.found = 1'b1;
        held.a_index = IDX_W'(a_drv ? i : best_idx);
        held.b_index = IDX_W'(a_drv ? best_idx : i);
        held.gap_ms = TOL_W'(best);
        held.last = 1'b0;
        held_ok = 1'b1;
      end
    end
    if (!held_ok) held = '0;
    held.last = 1'b1;
    match_q = {match_q, held};
    cnt_a = 0;
    cnt_b = 0;
  endtask

  task automatic apply_word(input in_word_t w);
    logic [STAMP_W-1:0] s;
    s = (w.stamp_ms > STAMP_MAX) ? STAMP_MAX : w.stamp_ms;
    case (w.action)
      ACT_LOAD_A: begin
        if (cnt_a < DEPTH) begin
          list_a[cnt_a] = s;
          cnt_a++;
        end
      end
      ACT_LOAD_B: begin
        if (cnt_b < DEPTH) begin
          list_b[cnt_b] = s;
          cnt_b++;
        end
      end
      ACT_START: merge_join();
      default: ;
    endcase
  endtask

  task automatic queue_word(input logic [ACTION_W-1:0] act, input logic [STAMP_W-1:0] st,
                            input bit hold);
    pend_item_t p;
    p.drain = hold;
    p.word.action = act;
    p.word.stamp_ms = st;
    pend_q = {pend_q, p};
    if (act != ACT_UNUSED) n_queued++;
  endtask

  task automatic add_set(input int unsigned na, input int unsigned nb,
                         input int unsigned tol_now, input bit drain_first);
    logic [STAMP_W-1:0] ta [0:79];
    logic [STAMP_W-1:0] tb [0:79];
    int unsigned step;
    int unsigned base;
    int unsigned t;
    int unsigned k;
    int unsigned ia;
    int unsigned ib;
    bit          messy;
    bit          lead;
    step = (tol_now == 0) ? 4 : ((tol_now > 20000) ? 40000 : tol_now * 2 + 1);
    messy = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 7) == 0) base = STAMP_MAX - 20 * step;
    else base = $urandom_range(0, STAMP_MAX - 90 * step);
    t = base;
    for (k = 0; k < na; k++) begin
      t = t + $urandom_range(0, step);
      ta[k] = messy ? STAMP_W'(base + $urandom_range(0, 80 * step)) : STAMP_W'(t);
      if ($urandom_range(0, 29) == 0) ta[k] = STAMP_W'($urandom());
    end
    t = base + $urandom_range(0, step);
    for (k = 0; k < nb; k++) begin
      t = t + $urandom_range(0, step);
      tb[k] = messy ? STAMP_W'(base + $urandom_range(0, 80 * step)) : STAMP_W'(t);
      if ($urandom_range(0, 29) == 0) tb[k] = STAMP_W'($urandom());
    end
    ia = 0;
    ib = 0;
    lead = drain_first;
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 24) == 0) queue_word(ACT_UNUSED, STAMP_W'($urandom()), 1'b0);
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        queue_word(ACT_LOAD_A, ta[ia], lead);
        ia++;
      end else begin
        queue_word(ACT_LOAD_B, tb[ib], lead);
        ib++;
      end
      lead = 1'b0;
    end
    queue_word(ACT_START, STAMP_W'($urandom()), lead);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pend_q.size() != 0 || in_valid || match_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_tol(input logic [TOL_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: a new word goes out once the previous one was taken.
  always @(negedge clk) begin
    if (!in_valid || word_taken) begin
      if (in_valid) in_gap = idle_len(calm);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        head = pend_q[0];
        if (!head.drain || match_q.size() == 0) begin
          in_word <= head.word;
          in_valid <= 1'b1;
          pend_q.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (press_arm && !hold_done && out_valid) begin
      stall_left = 300;
      hold_done = 1'b1;
    end else if (stall_left == 0) begin
      stall_left = idle_len(calm);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on every accepted input word and checks every output word.
  always @(posedge clk) begin
    word_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_we) tol_model = cfg_wdata;
      if (in_valid && !in_stall) apply_word(in_word);
      if (out_valid && !out_stall) begin
        if (match_q.size() == 0) begin
          n_bad++;
          $display("%0t: unexpected result, expected none, actual found=%0d a=%0d b=%0d ",
                   $time, out_word.found, out_word.a_index, out_word.b_index,
                   "gap=%0d last=%0d", out_word.gap_ms, out_word.last);
        end else begin
          want = match_q.pop_front();
          if (out_word !== want) begin
            n_bad++;
            $display("%0t: result mismatch, expected found=%0d a=%0d b=%0d gap=%0d last=%0d",
                     $time, want.found, want.a_index, want.b_index, want.gap_ms, want.last,
                     ", actual found=%0d a=%0d b=%0d gap=%0d last=%0d", out_word.found,
                     out_word.a_index, out_word.b_index, out_word.gap_ms, out_word.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, match_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned mark;
    int unsigned tol;
    rst_n <= 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    queue_word(ACT_START, '0, 1'b0);
    queue_word(ACT_LOAD_A, '0, 1'b0);
    queue_word(ACT_LOAD_B, '0, 1'b0);
    queue_word(ACT_START, '1, 1'b0);
    queue_word(ACT_LOAD_A, STAMP_MAX, 1'b0);
    queue_word(ACT_LOAD_B, '1, 1'b0);
    queue_word(ACT_START, '0, 1'b0);
    queue_word(ACT_UNUSED, 27'h5A5A5A5, 1'b0);
    queue_word(ACT_LOAD_A, 1000, 1'b0);
    queue_word(ACT_LOAD_B, 1501, 1'b0);
    queue_word(ACT_START, '0, 1'b0);
    queue_word(ACT_LOAD_B, 600, 1'b0);
    queue_word(ACT_LOAD_B, 1600, 1'b0);
    queue_word(ACT_LOAD_A, 1100, 1'b0);
    queue_word(ACT_START, '0, 1'b0);
    queue_word(ACT_LOAD_A, 5, 1'b0);
    queue_word(ACT_LOAD_A, 9, 1'b0);
    queue_word(ACT_LOAD_B, 7, 1'b0);
    queue_word(ACT_START, '0, 1'b0);
    queue_word(ACT_LOAD_B, 42, 1'b0);
    queue_word(ACT_START, '0, 1'b0);

    p = 1;
    while (n_queued < 420) begin
      wait_drained();
      case (p % 6)
        1, 2:    tol = 65535;
        3:       tol = 0;
        4:       tol = $urandom_range(1, 3000);
        5:       tol = 500;
        default: tol = $urandom_range(0, 65535);
      endcase
      write_tol(TOL_W'(tol));
      calm = (p % 3 == 0);
      mark = n_queued;
      if (p == 2) begin
        // The receiver holds off on the first word of a full-size run.
        press_arm = 1'b1;
        add_set(66, 64, tol, 1'b0);
        add_set($urandom_range(1, 10), $urandom_range(1, 10), tol, 1'b0);
        add_set($urandom_range(1, 10), $urandom_range(1, 10), tol, 1'b1);
      end else begin
        while (n_queued - mark < 60) begin
          add_set(pick_len(), pick_len(), tol, $urandom_range(0, 3) == 0);
        end
      end
      p++;
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
